>>> hdl/ipcls_pkg.sv
// Shared types, constants and the class mask function for the IPv4 prefix classifier.
// No dependencies; every other file of the block imports this package.
package ipcls_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int ADDR_W      = 32;
   localparam int CLASS_W     = 2;
   localparam int CLASS_COUNT = 4;
   localparam int ENTRY_W     = CLASS_W + ADDR_W;
   localparam int CNT_W       = 64;
   localparam int BYTES_W     = 16;
   localparam int MC_W        = 3;

   localparam logic [MC_W-1:0] MC_NONE = 3'd0;

   localparam logic [CLASS_W-1:0] CLS_32 = 2'd0;
   localparam logic [CLASS_W-1:0] CLS_24 = 2'd1;
   localparam logic [CLASS_W-1:0] CLS_23 = 2'd2;
   localparam logic [CLASS_W-1:0] CLS_20 = 2'd3;

   localparam logic [ADDR_W-1:0] MASK_32 = 32'hFFFF_FFFF;
   localparam logic [ADDR_W-1:0] MASK_24 = 32'hFFFF_FF00;
   localparam logic [ADDR_W-1:0] MASK_23 = 32'hFFFF_FE00;
   localparam logic [ADDR_W-1:0] MASK_20 = 32'hFFFF_F000;

   typedef enum logic [1:0] {
      ACT_CLASSIFY = 2'd0,
      ACT_INSTALL  = 2'd1,
      ACT_REMOVE   = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      SEL_CLS_PKT  = 2'd0,
      SEL_CLS_BYTE = 2'd1,
      SEL_TOT_PKT  = 2'd2,
      SEL_TOT_BYTE = 2'd3
   } cnt_sel_type;

   typedef struct packed {
      logic                 write;
      logic                 remove;
      logic [IDX_W-1:0]     index;
      logic [CLASS_W-1:0]   cls;
      logic [ADDR_W-1:0]    prefix;
   } tbl_cmd_type;

   typedef struct packed {
      logic                 clear;
      logic                 read;
      logic [IDX_W-1:0]     index;
   } walk_type;

   typedef struct packed {
      logic                 en;
      cnt_sel_type          sel;
      logic [CLASS_W-1:0]   cls;
      logic [BYTES_W-1:0]   bytes;
   } cnt_op_type;

   function automatic logic [ADDR_W-1:0] class_mask(input logic [CLASS_W-1:0] cls);
      logic [ADDR_W-1:0] m;
      case (cls)
         CLS_32:  m = MASK_32;
         CLS_24:  m = MASK_24;
         CLS_23:  m = MASK_23;
         CLS_20:  m = MASK_20;
         default: m = MASK_32;
      endcase
      return m;
   endfunction

endpackage

>>> hdl/ipv4_prefix_classifier_with_counters_unit.sv
// Top level of the IPv4 source-prefix classifier: command sequencer and result registers.
// Depends on ipcls_pkg, ipcls_table and ipcls_counters.
//
// A command is taken when start is high and busy is low; its single result appears on the
// rsp_ ports for exactly one cycle under rsp_valid and cannot be held off. A classify of an
// IPv4 frame walks every table slot through one compare unit, one slot per cycle from the
// slot memory, then makes up to four counter updates through one shared 64-bit adder, the
// class counters only on a match. Install, remove, the unused action code and a non-IPv4
// classify keep busy high for one cycle. The result shows in the cycle after busy falls,
// and a new command may be taken in that same cycle.
module ipv4_prefix_classifier_with_counters_unit
   import ipcls_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_action,
   input  logic [ADDR_W-1:0]   req_src_address,
   input  logic                req_is_ipv4,
   input  logic [BYTES_W-1:0]  req_frame_bytes,
   input  logic [7:0]          req_entry_index,
   input  logic [CLASS_W-1:0]  req_entry_class,
   input  logic [ADDR_W-1:0]   req_entry_prefix,
   output logic                rsp_valid,
   output logic                rsp_verdict,
   output logic [MC_W-1:0]     rsp_matched_class,
   output logic [CNT_W-1:0]    rsp_class_packet_count,
   output logic [CNT_W-1:0]    rsp_class_byte_count,
   output logic [CNT_W-1:0]    rsp_all_packet_count,
   output logic [CNT_W-1:0]    rsp_all_byte_count
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_WALK   = 5'b00010,
      ST_DRAIN  = 5'b00100,
      ST_COUNT  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_DEPTH - 1);

   state_type              state_ff, state_in;
   logic [IDX_W-1:0]       cnt_ff, cnt_in;
   logic [1:0]             step_ff, step_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic [BYTES_W-1:0]     bytes_ff, bytes_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   verdict_ff, verdict_in;
   logic [MC_W-1:0]        matched_ff, matched_in;
   logic [CNT_W-1:0]       cpk_ff, cpk_in;
   logic [CNT_W-1:0]       cby_ff, cby_in;
   logic [CNT_W-1:0]       apk_ff, apk_in;
   logic [CNT_W-1:0]       aby_ff, aby_in;

   tbl_cmd_type            tbl_cmd;
   walk_type               walk;
   cnt_op_type             cnt_op;
   logic [CLASS_COUNT-1:0] hits;
   logic                   any_hit;
   logic [CLASS_W-1:0]     win_cls;
   logic [31:0]            idx_ext;
   logic                   idx_in_range;
   logic [CNT_W-1:0]       cls_pkt, cls_byte, tot_pkt, tot_byte;

   ipcls_table u_table (
      .clock (clock),
      .reset (reset),
      .cmd   (tbl_cmd),
      .walk  (walk),
      .key   (addr_ff),
      .hits  (hits)
   );

   ipcls_counters u_counters (
      .clock    (clock),
      .reset    (reset),
      .op       (cnt_op),
      .cls_pkt  (cls_pkt),
      .cls_byte (cls_byte),
      .tot_pkt  (tot_pkt),
      .tot_byte (tot_byte)
   );

   assign idx_ext      = 32'(req_entry_index);
   assign idx_in_range = idx_ext < 32'(TABLE_DEPTH);
   assign any_hit      = |hits;

   // shortest prefix class loses: /32 first, then /24, /23, /20
   always_comb begin
      if (hits[0]) begin
         win_cls = CLS_32;
      end else if (hits[1]) begin
         win_cls = CLS_24;
      end else if (hits[2]) begin
         win_cls = CLS_23;
      end else begin
         win_cls = CLS_20;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      step_in      = step_ff;
      addr_in      = addr_ff;
      bytes_in     = bytes_ff;
      rsp_valid_in = 1'b0;
      verdict_in   = verdict_ff;
      matched_in   = matched_ff;
      cpk_in       = cpk_ff;
      cby_in       = cby_ff;
      apk_in       = apk_ff;
      aby_in       = aby_ff;

      tbl_cmd.write  = 1'b0;
      tbl_cmd.remove = 1'b0;
      tbl_cmd.index  = idx_ext[IDX_W-1:0];
      tbl_cmd.cls    = req_entry_class;
      tbl_cmd.prefix = req_entry_prefix;

      walk.clear = 1'b0;
      walk.read  = 1'b0;
      walk.index = cnt_ff;

      cnt_op.en    = 1'b0;
      cnt_op.sel   = cnt_sel_type'(step_ff);
      cnt_op.cls   = win_cls;
      cnt_op.bytes = bytes_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               addr_in    = req_src_address;
               bytes_in   = req_frame_bytes;
               walk.clear = 1'b1;
               if (req_action == ACT_CLASSIFY && req_is_ipv4) begin
                  cnt_in   = '0;
                  state_in = ST_WALK;
               end else begin
                  tbl_cmd.write  = (req_action == ACT_INSTALL) && idx_in_range;
                  tbl_cmd.remove = (req_action == ACT_REMOVE) && idx_in_range;
                  state_in       = ST_FINISH;
               end
            end
         end
         ST_WALK: begin
            walk.read = 1'b1;
            cnt_in    = cnt_ff + IDX_W'(1);
            if (cnt_ff == LAST_SLOT) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last slot compare is made here and registered into the hit flags
            step_in  = '0;
            state_in = ST_COUNT;
         end
         ST_COUNT: begin
            // class counters only on a match; totals always
            cnt_op.en = step_ff[1] | any_hit;
            step_in   = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            rsp_valid_in = 1'b1;
            verdict_in   = any_hit;
            matched_in   = any_hit ? (MC_W'(win_cls) + MC_W'(1)) : MC_NONE;
            cpk_in       = any_hit ? cls_pkt : '0;
            cby_in       = any_hit ? cls_byte : '0;
            apk_in       = tot_pkt;
            aby_in       = tot_byte;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff    <= addr_in;
      bytes_ff   <= bytes_in;
      verdict_ff <= verdict_in;
      matched_ff <= matched_in;
      cpk_ff     <= cpk_in;
      cby_ff     <= cby_in;
      apk_ff     <= apk_in;
      aby_ff     <= aby_in;
   end

   assign busy                   = (state_ff != ST_IDLE);
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_verdict            = verdict_ff;
   assign rsp_matched_class      = matched_ff;
   assign rsp_class_packet_count = cpk_ff;
   assign rsp_class_byte_count   = cby_ff;
   assign rsp_all_packet_count   = apk_ff;
   assign rsp_all_byte_count     = aby_ff;

endmodule

>>> hdl/ipcls_table.sv
// Prefix table: slot memory, per-slot valid flags and the single compare unit
// that a classify walk reuses once per slot. Depends on ipcls_pkg.
module ipcls_table
   import ipcls_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  tbl_cmd_type            cmd,
   input  walk_type               walk,
   input  logic [ADDR_W-1:0]      key,
   output logic [CLASS_COUNT-1:0] hits
);

   logic [ENTRY_W-1:0]     mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [ENTRY_W-1:0]     rd_entry_ff;
   logic                   rd_valid_ff;
   logic                   cmp_en_ff;
   logic [CLASS_COUNT-1:0] hit_ff, hit_in;

   logic [CLASS_W-1:0]     rd_cls;
   logic [ADDR_W-1:0]      rd_prefix;
   logic                   slot_hit;

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         mem[cmd.index] <= {cmd.cls, cmd.prefix & class_mask(cmd.cls)};
      end
      if (walk.read) begin
         rd_entry_ff <= mem[walk.index];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.write) begin
         valid_in[cmd.index] = 1'b1;
      end
      if (cmd.remove) begin
         valid_in[cmd.index] = 1'b0;
      end
   end

   assign rd_cls    = rd_entry_ff[ENTRY_W-1 -: CLASS_W];
   assign rd_prefix = rd_entry_ff[ADDR_W-1:0];
   assign slot_hit  = cmp_en_ff && rd_valid_ff && (rd_prefix == (key & class_mask(rd_cls)));

   always_comb begin
      if (walk.clear) begin
         hit_in = '0;
      end else if (slot_hit) begin
         hit_in = hit_ff | (CLASS_COUNT'(1) << rd_cls);
      end else begin
         hit_in = hit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
         cmp_en_ff   <= 1'b0;
         hit_ff      <= '0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[walk.index];
         cmp_en_ff   <= walk.read;
         hit_ff      <= hit_in;
      end
   end

   assign hits = hit_ff;

endmodule

>>> hdl/ipcls_counters.sv
// Packet and byte counter bank with one shared 64-bit adder, one update per cycle.
// Depends on ipcls_pkg.
module ipcls_counters
   import ipcls_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cnt_op_type       op,
   output logic [CNT_W-1:0] cls_pkt,
   output logic [CNT_W-1:0] cls_byte,
   output logic [CNT_W-1:0] tot_pkt,
   output logic [CNT_W-1:0] tot_byte
);

   logic [CNT_W-1:0] pkt_ff  [CLASS_COUNT];
   logic [CNT_W-1:0] byte_ff [CLASS_COUNT];
   logic [CNT_W-1:0] tot_pkt_ff, tot_byte_ff;

   logic [CNT_W-1:0] opnd_a, opnd_b, sum;

   assign cls_pkt  = pkt_ff[op.cls];
   assign cls_byte = byte_ff[op.cls];
   assign tot_pkt  = tot_pkt_ff;
   assign tot_byte = tot_byte_ff;

   always_comb begin
      case (op.sel)
         SEL_CLS_PKT:  opnd_a = cls_pkt;
         SEL_CLS_BYTE: opnd_a = cls_byte;
         SEL_TOT_PKT:  opnd_a = tot_pkt_ff;
         SEL_TOT_BYTE: opnd_a = tot_byte_ff;
         default:      opnd_a = tot_pkt_ff;
      endcase
      // packet counters step by one, byte counters by the frame length
      if (op.sel == SEL_CLS_PKT || op.sel == SEL_TOT_PKT) begin
         opnd_b = CNT_W'(1);
      end else begin
         opnd_b = CNT_W'(op.bytes);
      end
   end

   assign sum = opnd_a + opnd_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CLASS_COUNT; i++) begin
            pkt_ff[i]  <= '0;
            byte_ff[i] <= '0;
         end
         tot_pkt_ff  <= '0;
         tot_byte_ff <= '0;
      end else if (op.en) begin
         case (op.sel)
            SEL_CLS_PKT:  pkt_ff[op.cls]  <= sum;
            SEL_CLS_BYTE: byte_ff[op.cls] <= sum;
            SEL_TOT_PKT:  tot_pkt_ff      <= sum;
            SEL_TOT_BYTE: tot_byte_ff     <= sum;
            default:      tot_pkt_ff      <= tot_pkt_ff;
         endcase
      end
   end

endmodule

>>> hdl/ipcls_checker.sv
// Port-level checks for the IPv4 prefix classifier, bound to its top level.
// Depends on ipcls_pkg and ipv4_prefix_classifier_with_counters_unit.
module ipcls_checker
   import ipcls_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic               rsp_verdict,
   input logic [MC_W-1:0]    rsp_matched_class,
   input logic [CNT_W-1:0]   rsp_class_packet_count,
   input logic [CNT_W-1:0]   rsp_class_byte_count
);

   // an accepted command always raises busy in the following cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after a command transfer");

   // one result per command, never two in a row
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   // the result only appears once the command has finished
   a_idle_on_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_verdict) |->
         (rsp_matched_class == MC_NONE && rsp_class_packet_count == '0 &&
          rsp_class_byte_count == '0))
      else $error("dropped result carries class data");

   a_pass_class: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_verdict) |->
         (rsp_matched_class != MC_NONE && rsp_matched_class <= MC_W'(CLASS_COUNT)))
      else $error("passed result without a valid class");

endmodule

bind ipv4_prefix_classifier_with_counters_unit ipcls_checker u_ipcls_checker (.*);
